// File: rtl/core/rhpm_pkg.sv
// Shared constants and types for the rolling hash pattern matcher.
// No dependencies; rolling_hash_pattern_matcher and rhpm_mulmod import this package.
`timescale 1ns / 1ps

package rhpm_pkg;

    localparam int unsigned C_MAX_PATTERN = 64;
    localparam int unsigned C_RING_AW     = (C_MAX_PATTERN > 1) ? $clog2(C_MAX_PATTERN) : 1;
    localparam int unsigned C_CNT_W       = $clog2(C_MAX_PATTERN + 1);
    localparam int unsigned C_HASH_W      = 30;

    typedef logic [C_HASH_W-1:0] t_hash;

    localparam t_hash       C_MOD    = 30'd1000000007;
    localparam t_hash       C_BASE   = 30'd26;
    localparam t_hash       C_OFFSET = 30'd64;
    // Barrett constant floor(2^60 / modulus)
    localparam logic [30:0] C_MU     = 31'((64'd1 << 60) / 64'(C_MOD));

    localparam logic [1:0] MODE_RESTART = 2'd0;
    localparam logic [1:0] MODE_PATTERN = 2'd1;
    localparam logic [1:0] MODE_TEXT    = 2'd2;

    typedef struct packed {
        logic  start;
        t_hash a;
        t_hash b;
    } t_mm_req;

    typedef struct packed {
        logic  done;
        t_hash result;
    } t_mm_rsp;

endpackage

// File: rtl/core/rhpm_in_if.sv
// Input channel of the matcher: valid/ready handshake with mode and symbol.
// Depends on nothing.
`timescale 1ns / 1ps

interface rhpm_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] mode;
    logic [7:0] symbol;

    modport source (output valid, output mode, output symbol, input ready);
    modport sink   (input valid, input mode, input symbol, output ready);
endinterface

// File: rtl/core/rhpm_out_if.sv
// Result channel of the matcher: valid/ready handshake with match report.
// Depends on nothing.
`timescale 1ns / 1ps

interface rhpm_out_if;
    logic        valid;
    logic        ready;
    logic        match;
    logic [31:0] position;
    logic        pattern_too_long;

    modport source (output valid, output match, output position, output pattern_too_long,
                     input ready);
    modport sink   (input valid, input match, input position, input pattern_too_long,
                     output ready);
endinterface

// File: rtl/core/rolling_hash_pattern_matcher.sv
// Rolling hash pattern matcher: sequencer, hash state and prefix ring.
// Restart word: handled in ST_IDLE. Pattern word: up to two multiplier passes per word.
// Text word: the result word is valid after two, three or four passes through the shared
// multiplier and then ST_EMIT; the next word is taken once the sequencer is back in idle.
// One word in flight; a held result stalls the next text word, and with it the input.
// Synchronous active-low reset clears control and hash state, not data registers or ring.
// Uses rhpm_pkg, rhpm_in_if, rhpm_out_if and rhpm_mulmod.
`timescale 1ns / 1ps

module rolling_hash_pattern_matcher
    import rhpm_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    rhpm_in_if.sink    i_in,
    rhpm_out_if.source o_out
);

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_P_MUL1 = 8'b0000_0010,
        ST_P_MUL2 = 8'b0000_0100,
        ST_T_MUL1 = 8'b0000_1000,
        ST_T_MUL2 = 8'b0001_0000,
        ST_T_MUL3 = 8'b0010_0000,
        ST_T_MUL4 = 8'b0100_0000,
        ST_EMIT   = 8'b1000_0000
    } t_state;

    localparam logic [C_CNT_W-1:0] C_CNT_MAX  = C_CNT_W'(C_MAX_PATTERN);
    localparam logic [C_CNT_W:0]   C_DEPTH_X  = (C_CNT_W + 1)'(C_MAX_PATTERN);
    localparam logic [C_RING_AW-1:0] C_PTR_LAST = C_RING_AW'(C_MAX_PATTERN - 1);

    function automatic t_hash add_mod(input t_hash a, input t_hash b);
        logic [C_HASH_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, C_MOD}) begin
            s = s - {1'b0, C_MOD};
        end
        return s[C_HASH_W-1:0];
    endfunction

    function automatic t_hash sub_mod(input t_hash a, input t_hash b);
        t_hash d;
        if (a >= b) begin
            d = a - b;
        end else begin
            d = a + C_MOD - b;
        end
        return d;
    endfunction

    function automatic t_hash weight_of(input logic [7:0] sym);
        t_hash w;
        if (t_hash'(sym) >= C_OFFSET) begin
            w = t_hash'(sym) - C_OFFSET;
        end else begin
            w = t_hash'(sym) + C_MOD - C_OFFSET;
        end
        return w;
    endfunction

    t_state                r_state, n_state;
    t_hash                 r_ph, n_ph;
    t_hash                 r_pp, n_pp;
    logic [C_CNT_W-1:0]    r_pc, n_pc;
    logic                  r_flag, n_flag;
    t_hash                 r_prefix, n_prefix;
    t_hash                 r_tp, n_tp;
    t_hash                 r_wsp, n_wsp;
    logic [C_RING_AW-1:0]  r_ptr, n_ptr;
    logic [31:0]           r_tc, n_tc;
    logic [31:0]           r_i, n_i;
    logic [C_CNT_W-1:0]    r_m, n_m;
    t_hash                 r_win, n_win;
    logic                  r_match, n_match;
    t_hash                 r_old;
    logic                  r_out_valid, n_out_valid;
    logic                  r_out_match, n_out_match;
    logic [31:0]           r_out_pos, n_out_pos;
    logic                  r_out_ptl, n_out_ptl;

    t_hash                 ring [C_MAX_PATTERN];

    t_mm_req               mm_req;
    t_mm_rsp               mm_rsp;
    logic                  w_acc;
    t_hash                 w_weight;
    logic [C_CNT_W:0]      w_rd_full;
    logic [C_RING_AW-1:0]  w_rd_addr;
    logic                  w_ring_we;

    rhpm_mulmod u_mulmod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mm_req),
        .o_rsp   (mm_rsp)
    );

    assign i_in.ready             = (r_state == ST_IDLE);
    assign w_acc                  = i_in.valid && i_in.ready;
    assign w_weight               = weight_of(i_in.symbol);
    assign o_out.valid            = r_out_valid;
    assign o_out.match            = r_out_match;
    assign o_out.position         = r_out_pos;
    assign o_out.pattern_too_long = r_out_ptl;

    // slot of the prefix hash one pattern length back
    always_comb begin
        if ({{(C_CNT_W + 1 - C_RING_AW){1'b0}}, r_ptr} >= {1'b0, r_pc}) begin
            w_rd_full = {{(C_CNT_W + 1 - C_RING_AW){1'b0}}, r_ptr} - {1'b0, r_pc};
        end else begin
            w_rd_full = {{(C_CNT_W + 1 - C_RING_AW){1'b0}}, r_ptr} + C_DEPTH_X - {1'b0, r_pc};
        end
        w_rd_addr = w_rd_full[C_RING_AW-1:0];
    end

    assign w_ring_we = (r_state == ST_T_MUL2) && mm_rsp.done;

    always_comb begin
        n_state     = r_state;
        n_ph        = r_ph;
        n_pp        = r_pp;
        n_pc        = r_pc;
        n_flag      = r_flag;
        n_prefix    = r_prefix;
        n_tp        = r_tp;
        n_wsp       = r_wsp;
        n_ptr       = r_ptr;
        n_tc        = r_tc;
        n_i         = r_i;
        n_m         = r_m;
        n_win       = r_win;
        n_match     = r_match;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out_match = r_out_match;
        n_out_pos   = r_out_pos;
        n_out_ptl   = r_out_ptl;
        mm_req      = '0;

        case (r_state)
            ST_IDLE: begin
                if (w_acc) begin
                    case (i_in.mode)
                        MODE_RESTART: begin
                            n_ph     = '0;
                            n_pp     = t_hash'(1);
                            n_pc     = '0;
                            n_flag   = 1'b0;
                            n_prefix = '0;
                            n_tp     = t_hash'(1);
                            n_wsp    = t_hash'(1);
                            n_ptr    = '0;
                            n_tc     = '0;
                        end
                        MODE_PATTERN: begin
                            if (r_tc == '0) begin
                                if (r_pc < C_CNT_MAX) begin
                                    mm_req.start = 1'b1;
                                    mm_req.a     = w_weight;
                                    mm_req.b     = r_pp;
                                    n_state      = ST_P_MUL1;
                                end else begin
                                    n_flag = 1'b1;
                                end
                            end
                        end
                        MODE_TEXT: begin
                            n_i = r_tc;
                            n_m = r_pc;
                            if (r_tc != '1) begin
                                n_tc = r_tc + 32'd1;
                            end
                            mm_req.start = 1'b1;
                            mm_req.a     = w_weight;
                            mm_req.b     = r_tp;
                            n_state      = ST_T_MUL1;
                        end
                        default: ;
                    endcase
                end
            end
            ST_P_MUL1: begin
                if (mm_rsp.done) begin
                    n_ph         = add_mod(r_ph, mm_rsp.result);
                    mm_req.start = 1'b1;
                    mm_req.a     = r_pp;
                    mm_req.b     = C_BASE;
                    n_state      = ST_P_MUL2;
                end
            end
            ST_P_MUL2: begin
                if (mm_rsp.done) begin
                    n_pp    = mm_rsp.result;
                    n_pc    = r_pc + C_CNT_W'(1);
                    n_state = ST_IDLE;
                end
            end
            ST_T_MUL1: begin
                if (mm_rsp.done) begin
                    n_prefix     = add_mod(r_prefix, mm_rsp.result);
                    mm_req.start = 1'b1;
                    mm_req.a     = r_tp;
                    mm_req.b     = C_BASE;
                    n_state      = ST_T_MUL2;
                end
            end
            ST_T_MUL2: begin
                if (mm_rsp.done) begin
                    n_tp    = mm_rsp.result;
                    n_ptr   = (r_ptr == C_PTR_LAST) ? '0 : r_ptr + C_RING_AW'(1);
                    n_match = 1'b0;
                    if (r_m != '0 && r_i >= 32'(r_m) - 32'd1) begin
                        mm_req.start = 1'b1;
                        if (r_i >= 32'(r_m)) begin
                            mm_req.a = r_wsp;
                            mm_req.b = C_BASE;
                            n_state  = ST_T_MUL3;
                        end else begin
                            n_win    = r_prefix;
                            mm_req.a = r_ph;
                            mm_req.b = r_wsp;
                            n_state  = ST_T_MUL4;
                        end
                    end else begin
                        n_state = ST_EMIT;
                    end
                end
            end
            ST_T_MUL3: begin
                if (mm_rsp.done) begin
                    n_wsp        = mm_rsp.result;
                    n_win        = sub_mod(r_prefix, r_old);
                    mm_req.start = 1'b1;
                    mm_req.a     = r_ph;
                    mm_req.b     = mm_rsp.result;
                    n_state      = ST_T_MUL4;
                end
            end
            ST_T_MUL4: begin
                if (mm_rsp.done) begin
                    n_match = (r_win == mm_rsp.result);
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid = 1'b1;
                    n_out_match = r_match;
                    n_out_pos   = r_match ? r_i - 32'(r_m) + 32'd1 : '0;
                    n_out_ptl   = r_flag;
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_acc && i_in.mode == MODE_TEXT) begin
            r_old <= ring[w_rd_addr];
        end
        if (w_ring_we) begin
            ring[r_ptr] <= r_prefix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_ph        <= '0;
            r_pp        <= t_hash'(1);
            r_pc        <= '0;
            r_flag      <= 1'b0;
            r_prefix    <= '0;
            r_tp        <= t_hash'(1);
            r_wsp       <= t_hash'(1);
            r_ptr       <= '0;
            r_tc        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ph        <= n_ph;
            r_pp        <= n_pp;
            r_pc        <= n_pc;
            r_flag      <= n_flag;
            r_prefix    <= n_prefix;
            r_tp        <= n_tp;
            r_wsp       <= n_wsp;
            r_ptr       <= n_ptr;
            r_tc        <= n_tc;
            r_out_valid <= n_out_valid;
        end
        r_i         <= n_i;
        r_m         <= n_m;
        r_win       <= n_win;
        r_match     <= n_match;
        r_out_match <= n_out_match;
        r_out_pos   <= n_out_pos;
        r_out_ptl   <= n_out_ptl;
    end

endmodule

// File: rtl/core/rhpm_mulmod.sv
// Shared modular multiplier: a * b mod 1000000007 by Barrett reduction.
// One 32x32 multiplier reused over product, quotient and remainder; uses rhpm_pkg.
`timescale 1ns / 1ps

module rhpm_mulmod
    import rhpm_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_mm_req i_req,
    output t_mm_rsp o_rsp
);

    typedef enum logic [4:0] {
        MM_IDLE = 5'b00001,
        MM_PROD = 5'b00010,
        MM_QUO  = 5'b00100,
        MM_REM  = 5'b01000,
        MM_FIX  = 5'b10000
    } t_mm_state;

    localparam logic [31:0] C_MOD2 = {1'b0, C_MOD, 1'b0};

    t_mm_state   r_state, n_state;
    t_hash       r_a, n_a;
    t_hash       r_b, n_b;
    logic [59:0] r_x, n_x;
    logic [30:0] r_q, n_q;
    logic [31:0] r_r, n_r;

    logic [31:0] w_op_a;
    logic [31:0] w_op_b;
    logic [63:0] w_prod;
    logic [31:0] w_fix;

    always_comb begin
        case (r_state)
            MM_PROD: begin
                w_op_a = {2'b00, r_a};
                w_op_b = {2'b00, r_b};
            end
            MM_QUO: begin
                w_op_a = {1'b0, r_x[59:29]};
                w_op_b = {1'b0, C_MU};
            end
            MM_REM: begin
                w_op_a = {1'b0, r_q};
                w_op_b = {2'b00, C_MOD};
            end
            default: begin
                w_op_a = '0;
                w_op_b = '0;
            end
        endcase
        w_prod = w_op_a * w_op_b;
    end

    always_comb begin
        n_state = r_state;
        n_a     = r_a;
        n_b     = r_b;
        n_x     = r_x;
        n_q     = r_q;
        n_r     = r_r;
        if (i_req.start) begin
            n_state = MM_PROD;
            n_a     = i_req.a;
            n_b     = i_req.b;
        end else begin
            case (r_state)
                MM_IDLE: n_state = MM_IDLE;
                MM_PROD: begin
                    n_x     = w_prod[59:0];
                    n_state = MM_QUO;
                end
                MM_QUO: begin
                    n_q     = w_prod[61:31];
                    n_state = MM_REM;
                end
                MM_REM: begin
                    n_r     = r_x[31:0] - w_prod[31:0];
                    n_state = MM_FIX;
                end
                MM_FIX:  n_state = MM_IDLE;
                default: n_state = MM_IDLE;
            endcase
        end
    end

    // remainder is below three times the modulus
    always_comb begin
        if (r_r >= C_MOD2) begin
            w_fix = r_r - C_MOD2;
        end else if (r_r >= {2'b00, C_MOD}) begin
            w_fix = r_r - {2'b00, C_MOD};
        end else begin
            w_fix = r_r;
        end
    end

    assign o_rsp.done   = (r_state == MM_FIX);
    assign o_rsp.result = w_fix[C_HASH_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= MM_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_a <= n_a;
        r_b <= n_b;
        r_x <= n_x;
        r_q <= n_q;
        r_r <= n_r;
    end

endmodule
